### rtl/record_sorter_by_key_assert.svh
// Assertion macros for the record sorter checker.
`ifndef RECORD_SORTER_BY_KEY_ASSERT_SVH
`define RECORD_SORTER_BY_KEY_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define RSK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define RSK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rsk_pkg.sv
// Types, constants and key selection for the record sorter.
package rsk_pkg;

    localparam int FIELD_W  = 32;
    localparam int RECORD_W = 3 * FIELD_W;
    localparam int KEY_SEL_W = 2;

    typedef enum logic [KEY_SEL_W-1:0] {
        KEY_FIELD_ZERO = 2'd0,
        KEY_FIELD_ONE  = 2'd1,
        KEY_FIELD_TWO  = 2'd2
    } key_sel_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] field_two;
        logic signed [FIELD_W-1:0] field_one;
        logic signed [FIELD_W-1:0] field_zero;
    } record_t;

    typedef struct packed {
        logic load;
        logic shift_out;
    } cell_ctrl_t;

    // Unused selector code falls back to field zero.
    function automatic logic signed [FIELD_W-1:0] key_of(input record_t rec,
                                                         input logic [KEY_SEL_W-1:0] sel);
        logic signed [FIELD_W-1:0] k;
        case (sel)
            KEY_FIELD_ONE: k = rec.field_one;
            KEY_FIELD_TWO: k = rec.field_two;
            default:       k = rec.field_zero;
        endcase
        return k;
    endfunction

endpackage

### rtl/rsk_cell.sv
// One cell of the sorting chain: holds a record, inserts on a load or shifts on output.
module rsk_cell
    import rsk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [KEY_SEL_W-1:0] key_sel,
    input  cell_ctrl_t           ctrl,
    input  record_t              new_rec,
    input  record_t              prev_rec,
    input  logic                 prev_valid,
    input  logic                 prev_room,
    input  record_t              next_rec,
    input  logic                 next_valid,
    output record_t              rec,
    output logic                 valid,
    output logic                 make_room
);

    record_t rec_reg, rec_next;
    logic    valid_reg, valid_next;

    // Strictly greater key moves aside, so ties keep arrival order.
    assign make_room = !valid_reg || (key_of(rec_reg, key_sel) > key_of(new_rec, key_sel));

    always_comb begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctrl.shift_out) begin
            rec_next   = next_rec;
            valid_next = next_valid;
        end else if (ctrl.load && make_room) begin
            if (prev_room) begin
                rec_next   = prev_rec;
                valid_next = prev_valid;
            end else begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

### rtl/record_sorter_by_key.sv
// Record sorter top level: chain of insertion cells with stream ports.
//
//  Channel  | Direction | Payload                         | Marker
//  s_       | in        | field_zero, field_one, field_two | tlast = final_record
//  m_       | out       | out_zero, out_one, out_two       | tlast = out_last
//  cfg_wr   | in        | key_field                        | -
//
// Loading takes one cycle per record while s_tready is high; the chain inserts it in place as it arrives.
// After the final record, one result per cycle leaves cell 0 while m_tready is high.
// s_tready is low while a set drains; m_tready low simply holds the chain.
// Reset clears cell valid bits, count and key selector at once; no clearing pass.
module record_sorter_by_key
    import rsk_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [KEY_SEL_W-1:0] cfg_wr_data,   // key_field
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [RECORD_W-1:0]  s_tdata,       // field_zero, field_one, field_two
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [RECORD_W-1:0]  m_tdata,       // out_zero, out_one, out_two
    output logic                 m_tlast
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [KEY_SEL_W-1:0] key_sel_reg, key_sel_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 drain_reg, drain_next;

    logic       in_req, out_req;
    cell_ctrl_t ctrl;

    record_t cell_rec    [MAX_RECORDS];
    logic    cell_valid  [MAX_RECORDS];
    logic    cell_room   [MAX_RECORDS];

    assign s_tready = !drain_reg;
    assign in_req   = s_tvalid && s_tready;
    assign m_tvalid = drain_reg && cell_valid[0];
    assign out_req  = m_tvalid && m_tready;
    assign m_tdata  = cell_rec[0];
    assign m_tlast  = (count_reg == CNT_ONE);

    assign ctrl.load      = in_req && (count_reg != CNT_MAX);
    assign ctrl.shift_out = out_req;

    always_comb begin
        key_sel_next = cfg_wr_en ? cfg_wr_data : key_sel_reg;
        count_next   = count_reg;
        drain_next   = drain_reg;
        if (ctrl.load) begin
            count_next = count_reg + CNT_ONE;
        end
        if (in_req && s_tlast) begin
            drain_next = 1'b1;
        end
        if (out_req) begin
            count_next = count_reg - CNT_ONE;
            if (m_tlast) begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_sel_reg <= KEY_FIELD_ZERO;
            count_reg   <= '0;
            drain_reg   <= 1'b0;
        end else begin
            key_sel_reg <= key_sel_next;
            count_reg   <= count_next;
            drain_reg   <= drain_next;
        end
    end

    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        record_t prev_rec, next_rec;
        logic    prev_valid, prev_room, next_valid;

        if (i == 0) begin : g_head
            assign prev_rec   = '0;
            assign prev_valid = 1'b0;
            assign prev_room  = 1'b0;
        end else begin : g_body
            assign prev_rec   = cell_rec[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_room  = cell_room[i-1];
        end

        if (i == MAX_RECORDS - 1) begin : g_tail
            assign next_rec   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_rec   = cell_rec[i+1];
            assign next_valid = cell_valid[i+1];
        end

        rsk_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .key_sel    (key_sel_reg),
            .ctrl       (ctrl),
            .new_rec    (record_t'(s_tdata)),
            .prev_rec   (prev_rec),
            .prev_valid (prev_valid),
            .prev_room  (prev_room),
            .next_rec   (next_rec),
            .next_valid (next_valid),
            .rec        (cell_rec[i]),
            .valid      (cell_valid[i]),
            .make_room  (cell_room[i])
        );
    end

endmodule

### rtl/rsk_checker.sv
// Port-level assertion checker for the record sorter, bound to the top level.
`include "record_sorter_by_key_assert.svh"

module rsk_checker
    import rsk_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [RECORD_W-1:0]  m_tdata,
    input logic                 m_tlast
);

    `RSK_ASSERT_NOW(a_no_load_in_drain, m_tvalid, !s_tready, "input open while draining")

    `RSK_ASSERT_NEXT(a_final_starts_drain, s_tvalid && s_tready && s_tlast, m_tvalid && !s_tready, "no output after final request")

    `RSK_ASSERT_NEXT(a_last_ends_set, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "output continues after last")

    `RSK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind record_sorter_by_key rsk_checker u_rsk_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the record sorter: directed sets, then random sets.
`timescale 1ns / 1ps

module tb_top;
    import rsk_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int SETTLE     = 8;
    localparam int STALL_CAP  = 4000;
    localparam int RAND_ITEMS = 280;

    localparam logic [KEY_SEL_W-1:0] KEY_UNUSED = 2'd3;
    localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic                 fin;
        record_t              rec;
    } sorted_entry_t;

    typedef struct {
        logic                 wr_key;
        logic [KEY_SEL_W-1:0] key;
        record_t              rec;
        logic                 fin;
        logic                 typed;
        record_t              exp;
    } plan_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [KEY_SEL_W-1:0] cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [RECORD_W-1:0]  s_tdata     = '0;   // field_zero, field_one, field_two
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [RECORD_W-1:0]  m_tdata;            // out_zero, out_one, out_two
    logic                 m_tlast;

    // predictor state
    record_t              held_recs[$];
    record_t              ordered[0:CAPACITY-1];
    logic [KEY_SEL_W-1:0] key_now = KEY_FIELD_ZERO;

    sorted_entry_t        sorted_due[$];
    plan_row_t            plan[$];
    logic                 steady = 1'b0;
    int                   fails = 0;
    int                   idle_cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    record_sorter_by_key #(
        .MAX_RECORDS(CAPACITY)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    function automatic record_t pack_record(logic signed [FIELD_W-1:0] f0,
                                            logic signed [FIELD_W-1:0] f1,
                                            logic signed [FIELD_W-1:0] f2);
        record_t r;
        r.field_zero = f0;
        r.field_one  = f1;
        r.field_two  = f2;
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] sort_field(record_t r,
                                                             logic [KEY_SEL_W-1:0] sel);
        logic signed [FIELD_W-1:0] k;
        case (sel)
            KEY_FIELD_ONE: k = r.field_one;
            KEY_FIELD_TWO: k = r.field_two;
            default:       k = r.field_zero;
        endcase
        return k;
    endfunction

    // Store the record (dropped when full); on the final one, stable-sort the set
    // into ordered[] and return its size.
    function automatic int load_and_sort(record_t rec, logic fin);
        int      n;
        int      j;
        record_t tmp;
        if (held_recs.size() < CAPACITY)
            held_recs.push_back(rec);
        if (!fin)
            return 0;
        n = held_recs.size();
        for (int i = 0; i < n; i++)
            ordered[i] = held_recs[i];
        for (int i = 1; i < n; i++) begin
            tmp = ordered[i];
            j = i;
            while (j > 0 && sort_field(ordered[j-1], key_now) > sort_field(tmp, key_now)) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = tmp;
        end
        held_recs.delete();
        return n;
    endfunction

    function automatic logic signed [FIELD_W-1:0] draw_field();
        logic signed [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = S_MIN;
            1:       v = S_MAX;
            2:       v = 0;
            3:       v = -1;
            4, 5, 6: v = $signed($urandom_range(0, 6)) - 3;   // narrow range: plenty of ties
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void add_row(logic wr, logic [KEY_SEL_W-1:0] key,
                                    logic signed [FIELD_W-1:0] f0,
                                    logic signed [FIELD_W-1:0] f1,
                                    logic signed [FIELD_W-1:0] f2, logic fin);
        plan_row_t r;
        r.wr_key = wr;
        r.key    = key;
        r.rec    = pack_record(f0, f1, f2);
        r.fin    = fin;
        r.typed  = 1'b0;
        r.exp    = '0;
        plan.push_back(r);
    endfunction

    // Single-record set: the result is typed in.
    function automatic void add_typed(logic signed [FIELD_W-1:0] f0,
                                      logic signed [FIELD_W-1:0] f1,
                                      logic signed [FIELD_W-1:0] f2,
                                      logic signed [FIELD_W-1:0] e0,
                                      logic signed [FIELD_W-1:0] e1,
                                      logic signed [FIELD_W-1:0] e2);
        plan_row_t r;
        r.wr_key = 1'b0;
        r.key    = KEY_FIELD_ZERO;
        r.rec    = pack_record(f0, f1, f2);
        r.fin    = 1'b1;
        r.typed  = 1'b1;
        r.exp    = pack_record(e0, e1, e2);
        plan.push_back(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_record(record_t rec, logic fin, logic typed, record_t exp);
        int            n;
        sorted_entry_t e;
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        n = load_and_sort(rec, fin);
        if (typed) begin
            e.rec = exp;
            e.fin = 1'b1;
            sorted_due.push_back(e);
        end else begin
            for (int k = 0; k < n; k++) begin
                e.rec = ordered[k];
                e.fin = (k == n - 1);
                sorted_due.push_back(e);
            end
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sorted_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_key(logic [KEY_SEL_W-1:0] k);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        key_now = k;
    endtask

    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 25);

    always @(posedge aclk) begin
        sorted_entry_t want;
        record_t       got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (sorted_due.size() == 0) begin
                $display("%0t: result with nothing expected: %0d %0d %0d last %b",
                         $time, got.field_zero, got.field_one, got.field_two, m_tlast);
                fails++;
            end else begin
                want = sorted_due.pop_front();
                if (got.field_zero !== want.rec.field_zero) begin
                    $display("%0t: out_zero expected %0d got %0d",
                             $time, want.rec.field_zero, got.field_zero);
                    fails++;
                end
                if (got.field_one !== want.rec.field_one) begin
                    $display("%0t: out_one expected %0d got %0d",
                             $time, want.rec.field_one, got.field_one);
                    fails++;
                end
                if (got.field_two !== want.rec.field_two) begin
                    $display("%0t: out_two expected %0d got %0d",
                             $time, want.rec.field_two, got.field_two);
                    fails++;
                end
                if (m_tlast !== want.fin) begin
                    $display("%0t: out_last expected %b got %b", $time, want.fin, m_tlast);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_CAP) begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        int set_no;
        int set_len;

        add_typed(S_MIN, S_MAX, 0, S_MIN, S_MAX, 0);
        add_typed(S_MAX, -1, S_MIN, S_MAX, -1, S_MIN);
        add_typed(0, S_MIN, S_MAX, 0, S_MIN, S_MAX);
        // key after reset: field zero, signed order, tie on -3
        add_row(1'b0, KEY_FIELD_ZERO, 5, 1, 0, 1'b0);
        add_row(1'b0, KEY_FIELD_ZERO, -3, 2, 0, 1'b0);
        add_row(1'b0, KEY_FIELD_ZERO, S_MAX, 3, 0, 1'b0);
        add_row(1'b0, KEY_FIELD_ZERO, S_MIN, 4, 0, 1'b0);
        add_row(1'b0, KEY_FIELD_ZERO, 0, 5, 0, 1'b0);
        add_row(1'b0, KEY_FIELD_ZERO, -3, 6, 0, 1'b1);
        add_row(1'b1, KEY_FIELD_ONE, 1, -7, 9, 1'b0);
        add_row(1'b0, KEY_FIELD_ONE, 2, 100, 8, 1'b0);
        add_row(1'b0, KEY_FIELD_ONE, 3, -7, 7, 1'b0);
        add_row(1'b0, KEY_FIELD_ONE, 4, S_MIN, 6, 1'b1);
        add_row(1'b1, KEY_FIELD_TWO, 1, 1, S_MAX, 1'b0);
        add_row(1'b0, KEY_FIELD_TWO, 2, 2, -1, 1'b0);
        add_row(1'b0, KEY_FIELD_TWO, 3, 3, -1, 1'b0);
        add_row(1'b0, KEY_FIELD_TWO, 4, 4, 0, 1'b1);
        // unused selector code sorts on field zero
        add_row(1'b1, KEY_UNUSED, 9, 0, -5, 1'b0);
        add_row(1'b0, KEY_UNUSED, -9, 1, 5, 1'b0);
        add_row(1'b0, KEY_UNUSED, 0, 2, 0, 1'b1);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].wr_key)
                write_key(plan[i].key);
            push_record(plan[i].rec, plan[i].fin, plan[i].typed, plan[i].exp);
        end

        sent = 0;
        set_no = 0;
        while (sent < RAND_ITEMS) begin
            if (set_no == 0)
                write_key(KEY_FIELD_ZERO);
            else if ($urandom_range(0, 2) == 0)
                write_key(KEY_SEL_W'($urandom_range(0, 3)));
            else if ($urandom_range(0, 5) == 0)
                wait_drained();
            steady = (set_no >= 4 && set_no < 9);
            // overfull set first (last two requests dropped), then an exactly full one
            if (set_no == 0)
                set_len = CAPACITY + 2;
            else if (set_no == 1)
                set_len = CAPACITY;
            else if ($urandom_range(0, 24) == 0)
                set_len = $urandom_range(CAPACITY, CAPACITY + 2);
            else
                set_len = $urandom_range(1, 12);
            for (int k = 0; k < set_len; k++)
                push_record(pack_record(draw_field(), draw_field(), draw_field()),
                            k == set_len - 1, 1'b0, '0);
            sent += set_len;
            set_no++;
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (sorted_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
